/* src/rne_pkg.sv */
// shared types, constants and digit helpers for the roman numeral encoder
package rne_pkg;

    localparam logic [11:0] VALUE_MAX = 12'd3999;

    localparam logic [7:0] CHAR_I = 8'h49;
    localparam logic [7:0] CHAR_V = 8'h56;
    localparam logic [7:0] CHAR_X = 8'h58;
    localparam logic [7:0] CHAR_L = 8'h4c;
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_D = 8'h44;
    localparam logic [7:0] CHAR_M = 8'h4d;
    localparam logic [7:0] CHAR_NONE = 8'h00;

    // decade slots, most significant first
    localparam logic [1:0] DEC_THOU = 2'd0;
    localparam logic [1:0] DEC_HUND = 2'd1;
    localparam logic [1:0] DEC_TENS = 2'd2;
    localparam logic [1:0] DEC_UNIT = 2'd3;

    // which letter of a decade
    localparam logic [1:0] SEL_ONE  = 2'd0;
    localparam logic [1:0] SEL_FIVE = 2'd1;
    localparam logic [1:0] SEL_TEN  = 2'd2;

    typedef logic [3:0] t_digit;

    typedef struct packed {
        logic           err;
        t_digit [3:0]   dig;
    } t_entry;

    typedef struct packed {
        t_digit         q;
        logic [11:0]    rem;
    } t_split;

    // one decimal digit off the top of rem, by parallel compares
    function automatic t_split split_dec(input logic [11:0] rem, input logic [11:0] unit);
        t_split      res;
        logic [15:0] prod;
        logic [15:0] sub;
        res.q = 4'd0;
        sub = 16'd0;
        for (int k = 1; k <= 9; k++) begin
            prod = 16'(k * unit);
            if ({4'b0, rem} >= prod) begin
                res.q = 4'(k);
                sub = prod;
            end
        end
        res.rem = rem - sub[11:0];
        return res;
    endfunction

    function automatic logic [2:0] dig_len(input t_digit d);
        logic [2:0] len;
        case (d)
            4'd1: len = 3'd1;
            4'd2: len = 3'd2;
            4'd3: len = 3'd3;
            4'd4: len = 3'd2;
            4'd5: len = 3'd1;
            4'd6: len = 3'd2;
            4'd7: len = 3'd3;
            4'd8: len = 3'd4;
            4'd9: len = 3'd2;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [1:0] letter_sel(input t_digit d, input logic [1:0] pos);
        logic [1:0] sel;
        sel = SEL_ONE;
        if (d == 4'd9) begin
            sel = (pos == 2'd0) ? SEL_ONE : SEL_TEN;
        end else if (d == 4'd4) begin
            sel = (pos == 2'd0) ? SEL_ONE : SEL_FIVE;
        end else if (d >= 4'd5) begin
            sel = (pos == 2'd0) ? SEL_FIVE : SEL_ONE;
        end
        return sel;
    endfunction

    function automatic logic [7:0] dec_letter(input logic [1:0] dec, input logic [1:0] sel);
        logic [7:0] c;
        case (dec)
            DEC_THOU: c = CHAR_M;
            DEC_HUND: c = (sel == SEL_ONE) ? CHAR_C : (sel == SEL_FIVE) ? CHAR_D : CHAR_M;
            DEC_TENS: c = (sel == SEL_ONE) ? CHAR_X : (sel == SEL_FIVE) ? CHAR_L : CHAR_C;
            default:  c = (sel == SEL_ONE) ? CHAR_I : (sel == SEL_FIVE) ? CHAR_V : CHAR_X;
        endcase
        return c;
    endfunction

endpackage

/* src/rne_in_if.sv */
// request channel carrying one integer value
interface rne_in_if;
    logic           valid;
    logic           ready;
    logic [11:0]    value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

/* src/rne_out_if.sv */
// result channel carrying one numeral letter
interface rne_out_if;
    logic           valid;
    logic           ready;
    logic [7:0]     symbol;
    logic           last;
    logic           error;

    modport source (output valid, output symbol, output last, output error, input ready);
    modport sink   (input valid, input symbol, input last, input error, output ready);
endinterface

/* src/rne_front.sv */
// front end: range check and decimal split of one request
module rne_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    rne_in_if.sink          i_req,
    output logic            o_push_valid,
    input  logic            i_push_ready,
    output rne_pkg::t_entry o_push_data
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_THOU = 2'd1;
    localparam logic [1:0] F_HUND = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]             r_state;
    logic [11:0]            r_rem;
    logic                   r_err;
    rne_pkg::t_digit        r_thou;
    rne_pkg::t_digit        r_hund;
    rne_pkg::t_split        split_thou;
    rne_pkg::t_split        split_hund;
    rne_pkg::t_split        split_tens;
    logic                   bad;

    assign bad = (i_req.value == 12'd0) || (i_req.value > rne_pkg::VALUE_MAX);

    always_comb begin
        split_thou = rne_pkg::split_dec(r_rem, 12'd1000);
        split_hund = rne_pkg::split_dec(r_rem, 12'd100);
        split_tens = rne_pkg::split_dec(r_rem, 12'd10);
    end

    assign i_req.ready  = (r_state == F_IDLE);
    assign o_push_valid = (r_state == F_PUSH);

    always_comb begin
        o_push_data.err                    = r_err;
        o_push_data.dig[rne_pkg::DEC_THOU] = r_thou;
        o_push_data.dig[rne_pkg::DEC_HUND] = r_hund;
        o_push_data.dig[rne_pkg::DEC_TENS] = split_tens.q;
        o_push_data.dig[rne_pkg::DEC_UNIT] = split_tens.rem[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_req.valid) begin
                        r_state <= bad ? F_PUSH : F_THOU;
                    end
                end
                F_THOU: r_state <= F_HUND;
                F_HUND: r_state <= F_PUSH;
                F_PUSH: begin
                    if (i_push_ready) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                if (i_req.valid) begin
                    r_rem <= i_req.value;
                    r_err <= bad;
                end
            end
            F_THOU: begin
                r_thou <= split_thou.q;
                r_rem  <= split_thou.rem;
            end
            F_HUND: begin
                r_hund <= split_hund.q;
                r_rem  <= split_hund.rem;
            end
            default: begin
            end
        endcase
    end

endmodule

/* src/rne_queue.sv */
// two-entry queue between front and back
module rne_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  rne_pkg::t_entry i_push_data,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output rne_pkg::t_entry o_pop_data
);

    rne_pkg::t_entry    r_mem [2];
    logic               r_wp;
    logic               r_rp;
    logic [1:0]         r_cnt;
    logic               push;
    logic               pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_data   = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

endmodule

/* src/rne_back.sv */
// back end: letter sequencer with output register
module rne_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_pop_valid,
    output logic            o_pop_ready,
    input  rne_pkg::t_entry i_pop_data,
    rne_out_if.source       o_res
);

    logic                   r_busy;
    logic                   r_err;
    rne_pkg::t_digit [3:0]  r_dig;
    logic [1:0]             r_dec;
    logic [1:0]             r_pos;
    logic                   r_ovalid;
    logic [7:0]             r_osym;
    logic                   r_olast;
    logic                   r_oerr;

    rne_pkg::t_digit        cur;
    logic [2:0]             len;
    logic                   rest_zero;
    logic                   end_dig;
    logic                   out_free;
    logic [7:0]             sym;

    assign out_free    = !r_ovalid || o_res.ready;
    assign o_pop_ready = !r_busy;

    always_comb begin
        cur = r_dig[r_dec];
        len = rne_pkg::dig_len(cur);
        sym = rne_pkg::dec_letter(r_dec, rne_pkg::letter_sel(cur, r_pos));
        end_dig = ({1'b0, r_pos} == (len - 3'd1));
        rest_zero = 1'b1;
        for (int j = 0; j < 4; j++) begin
            if ((2'(j) > r_dec) && (r_dig[j] != 4'd0)) begin
                rest_zero = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (!r_busy) begin
                if (o_res.ready) begin
                    r_ovalid <= 1'b0;
                end
                if (i_pop_valid) begin
                    r_busy <= 1'b1;
                end
            end else if (out_free) begin
                if (r_err) begin
                    r_ovalid <= 1'b1;
                    r_busy   <= 1'b0;
                end else if (len == 3'd0) begin
                    // empty decade, step over it
                    r_ovalid <= 1'b0;
                    if (r_dec == rne_pkg::DEC_UNIT) begin
                        r_busy <= 1'b0;
                    end
                end else begin
                    r_ovalid <= 1'b1;
                    if (end_dig && rest_zero) begin
                        r_busy <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy) begin
            if (i_pop_valid) begin
                r_err <= i_pop_data.err;
                r_dig <= i_pop_data.dig;
                r_dec <= rne_pkg::DEC_THOU;
                r_pos <= 2'd0;
            end
        end else if (out_free) begin
            if (r_err) begin
                r_osym  <= rne_pkg::CHAR_NONE;
                r_olast <= 1'b1;
                r_oerr  <= 1'b1;
            end else if (len == 3'd0) begin
                r_dec <= r_dec + 2'd1;
            end else begin
                r_osym  <= sym;
                r_olast <= end_dig && rest_zero;
                r_oerr  <= 1'b0;
                if (end_dig) begin
                    r_pos <= 2'd0;
                    r_dec <= r_dec + 2'd1;
                end else begin
                    r_pos <= r_pos + 2'd1;
                end
            end
        end
    end

    assign o_res.valid  = r_ovalid;
    assign o_res.symbol = r_osym;
    assign o_res.last   = r_olast;
    assign o_res.error  = r_oerr;

endmodule

/* src/integer_to_roman_numeral_encoder_unit.sv */
// Integer to Roman numeral encoder, top level.
// Takes one value per request and returns its Roman numeral as ASCII letters, one letter
// per result, with last set on the final letter; a value of 0 or above 3999 gives a single
// result with error set, symbol zero and last set. The front end takes a request while idle
// and splits it into decimal digits (thousands, hundreds, then tens and units as it offers
// the split), skipping the split for an out of range value, before handing it to a
// two-entry queue; it takes no new request until it has pushed the last one. The back end
// loads a queued value, then emits one letter per cycle while the result side is ready, and
// steps over each zero digit ahead of the last letter without emitting, leading zeros
// included; a numeral has 1 to 15 letters, the most for 3888. The letter sequencer in the
// back end sets the sustained rate for long numerals and the front end for short ones; the
// front end splits the next value while the current one is still being emitted.
module integer_to_roman_numeral_encoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rne_in_if.sink      i_req,
    rne_out_if.source   o_res
);

    logic               push_valid;
    logic               push_ready;
    rne_pkg::t_entry    push_data;
    logic               pop_valid;
    logic               pop_ready;
    rne_pkg::t_entry    pop_data;

    rne_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    rne_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    rne_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_data  (pop_data),
        .o_res       (o_res)
    );

endmodule

/* src/rne_checker.sv */
// port-level checks for the roman numeral encoder, bound to the top level
module rne_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_symbol,
    input  logic        i_last,
    input  logic        i_error
);

    // a stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_symbol)
            && $stable(i_last) && $stable(i_error))
        else $error("stalled result changed");

    // out of range result is a single empty marked letter
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_error |-> i_last && (i_symbol == rne_pkg::CHAR_NONE))
        else $error("bad error result");

    // normal letters are numeral letters only
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_error |->
            (i_symbol == rne_pkg::CHAR_I) || (i_symbol == rne_pkg::CHAR_V)
            || (i_symbol == rne_pkg::CHAR_X) || (i_symbol == rne_pkg::CHAR_L)
            || (i_symbol == rne_pkg::CHAR_C) || (i_symbol == rne_pkg::CHAR_D)
            || (i_symbol == rne_pkg::CHAR_M))
        else $error("illegal letter");

    // reset clears the result register
    assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind integer_to_roman_numeral_encoder_unit rne_checker u_rne_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_symbol    (o_res.symbol),
    .i_last      (o_res.last),
    .i_error     (o_res.error)
);
